/* hw/rtl/base64_stream_decoder_assert.svh */
// assertion macros used by the decoder back end
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// checked on every edge outside reset
`define B64SD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define B64SD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/b64sd_pkg.sv */
// shared types, constants and the alphabet lookup for the base64 decoder
`timescale 1ns / 1ps
`default_nettype none

package b64sd_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam int QUEUE_DEPTH = 4; // power of two
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_BAD_CHAR  = 2'd1,
        ERR_EARLY_PAD = 2'd2,
        ERR_LENGTH    = 2'd3
    } t_err;

    // one decoded group handed from front to back
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;   // 0 means a lone end-of-string beat
        t_err        err;
        logic        fin;
    } t_job;

    // top bit set for a character outside the alphabet
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [6:0] res;
        res = {1'b1, 6'd0};
        if (c >= 8'h41 && c <= 8'h5A) begin
            res = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            res = {1'b0, 6'(c - 8'd71)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b0, 6'(c + 8'd4)};
        end else if (c == 8'h2B) begin
            res = {1'b0, 6'd62};
        end else if (c == 8'h2F) begin
            res = {1'b0, 6'd63};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/b64sd_front.sv */
// front end: takes characters, tracks group state and forms decode jobs
`timescale 1ns / 1ps
`default_nettype none

module b64sd_front
    import b64sd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_char,
    input  wire logic       i_final,
    input  wire logic       i_space,
    output logic            o_ready,
    output logic            o_push,
    output t_job            o_job
);

    logic [17:0] r_buf, n_buf;
    logic [1:0]  r_pos, n_pos;
    logic        r_pad, n_pad;
    t_err        r_err, n_err;

    logic        w_accept;
    logic [6:0]  w_map;
    logic        w_is_pad;
    t_err        w_e, w_err1, w_err2, w_err3;
    logic [1:0]  w_nbytes;
    logic        w_padded;

    assign o_ready  = i_space;
    assign w_accept = i_valid && i_space;
    assign w_map    = map_char(i_char);
    assign w_is_pad = (i_char == PAD_CHAR);
    assign w_padded = w_is_pad || r_pad;

    always_comb begin
        w_e      = ERR_OK;
        n_buf    = r_buf;
        n_pos    = r_pos;
        n_pad    = r_pad;
        w_nbytes = 2'd0;

        if (w_is_pad) begin
            if (r_pos < 2'd2) begin
                w_e = ERR_EARLY_PAD;
            end
        end else begin
            if (w_map[6]) begin
                w_e = ERR_BAD_CHAR;
            end
            if (r_pos == 2'd3 && r_pad) begin
                w_e = ERR_EARLY_PAD;
            end
        end
        w_err1 = (r_err == ERR_OK) ? w_e : r_err;
        w_err2 = w_err1;

        if (r_pos == 2'd3) begin
            // padded group must close the string
            if (w_padded && !i_final && w_err1 == ERR_OK) begin
                w_err2 = ERR_EARLY_PAD;
            end
            if (w_err2 == ERR_OK) begin
                w_nbytes = r_pad ? 2'd1 : (w_is_pad ? 2'd2 : 2'd3);
            end
            n_buf = '0;
            n_pad = 1'b0;
            n_pos = 2'd0;
        end else begin
            n_buf = {r_buf[11:0], w_map[5:0]};
            n_pos = r_pos + 2'd1;
            if (w_is_pad && r_pos == 2'd2) begin
                n_pad = 1'b1;
            end
        end

        w_err3 = w_err2;
        if (i_final && n_pos != 2'd0 && w_err2 == ERR_OK) begin
            w_err3 = ERR_LENGTH;
        end

        n_err = w_err3;
        if (i_final) begin
            n_buf = '0;
            n_pos = 2'd0;
            n_pad = 1'b0;
            n_err = ERR_OK;
        end
    end

    assign o_push       = w_accept && (w_nbytes != 2'd0 || i_final);
    assign o_job.word   = {r_buf, w_map[5:0]};
    assign o_job.nbytes = w_nbytes;
    assign o_job.err    = w_err3;
    assign o_job.fin    = i_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_pos <= 2'd0;
            r_pad <= 1'b0;
            r_err <= ERR_OK;
        end else if (w_accept) begin
            r_buf <= n_buf;
            r_pos <= n_pos;
            r_pad <= n_pad;
            r_err <= n_err;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/b64sd_queue.sv */
// short job queue between the front end and the byte emitter
`timescale 1ns / 1ps
`default_nettype none

module b64sd_queue
    import b64sd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_space,
    output logic      o_head_valid,
    output t_job      o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    logic w_wr, w_rd;

    assign o_space      = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    assign w_wr = i_push && o_space;
    assign w_rd = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/b64sd_back.sv */
// back end: splits each job into byte beats behind an output register
`timescale 1ns / 1ps
`default_nettype none

`include "base64_stream_decoder_assert.svh"

module b64sd_back
    import b64sd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_job_valid,
    input  wire t_job       i_job,
    output logic            o_pop,
    input  wire logic       i_ready,
    output logic            o_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_run_last,
    output logic            o_stream_end,
    output logic [1:0]      o_error_code
);

    logic [1:0] r_idx, n_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_bv;
    logic       r_rl;
    logic       r_se;
    t_err       r_err;

    logic       w_load;
    logic       w_last;
    logic [7:0] w_byte;

    assign w_load = i_job_valid && (!r_valid || i_ready);
    // an empty job still gives its one end-of-string beat
    assign w_last = (i_job.nbytes == 2'd0) || (r_idx == i_job.nbytes - 2'd1);
    assign o_pop  = w_load && w_last;

    always_comb begin
        case (r_idx)
            2'd0:    w_byte = i_job.word[23:16];
            2'd1:    w_byte = i_job.word[15:8];
            2'd2:    w_byte = i_job.word[7:0];
            default: w_byte = 8'd0;
        endcase
        if (i_job.nbytes == 2'd0) begin
            w_byte = 8'd0;
        end
        n_idx = r_idx;
        if (w_load) begin
            n_idx = w_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_idx <= n_idx;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_bv   <= (i_job.nbytes != 2'd0);
            r_rl   <= w_last;
            r_se   <= w_last && i_job.fin;
            r_err  <= i_job.err;
        end
    end

    assign o_valid      = r_valid;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_bv;
    assign o_run_last   = r_rl;
    assign o_stream_end = r_se;
    assign o_error_code = r_err;

    `B64SD_ASSERT(a_empty_beat_ends, r_valid && !r_bv |-> r_rl && r_se, "empty beat not at end")
    `B64SD_ASSERT(a_end_is_last, r_valid && r_se |-> r_rl, "stream end without run last")
    `B64SD_ASSERT(a_pop_has_job, o_pop |-> i_job_valid, "pop from empty queue")
    `B64SD_ASSERT_ALWAYS(a_idx_range, !i_rst_n || r_idx != 2'd3, "byte index out of range")

endmodule

`default_nettype wire

/* hw/rtl/base64_stream_decoder.sv */
// Base64 decoder (standard alphabet) taking one character per beat and giving
// one decoded byte per beat. A character is taken every cycle while the job
// queue has room; each fourth character of a group yields up to three bytes,
// emitted one per cycle by the back end while i_ready is high, so sustained
// input is one character per cycle; each job goes through the queue and the
// output register. The final character always yields an end-of-string beat
// carrying the first error of the string (bad character, misplaced padding or
// a length that is not a multiple of four); groups with an error give no bytes.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder
    import b64sd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_in_final,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_run_last,
    output logic            o_stream_end,
    output logic [1:0]      o_error_code
);

    logic w_space;
    logic w_push;
    t_job w_job;
    logic w_head_valid;
    t_job w_head;
    logic w_pop;

    b64sd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_char  (i_in_char),
        .i_final (i_in_final),
        .i_space (w_space),
        .o_ready (o_ready),
        .o_push  (w_push),
        .o_job   (w_job)
    );

    b64sd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_job        (w_job),
        .i_pop        (w_pop),
        .o_space      (w_space),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    b64sd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_head_valid),
        .i_job        (w_head),
        .o_pop        (w_pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_run_last   (o_run_last),
        .o_stream_end (o_stream_end),
        .o_error_code (o_error_code)
    );

endmodule

`default_nettype wire
